>>> rtl/nirfd_pkg.sv
// shared types and timing limits of the nec infrared frame decoder
package nirfd_pkg;

	localparam int unsigned LEN_W = 16;
	localparam int unsigned POS_W = 7;
	localparam int unsigned TICK_W = 4;

	localparam logic [LEN_W-1:0] HDR_MARK_MIN   = 16'd4500;
	localparam logic [LEN_W-1:0] HDR_MARK_MAX   = 16'd13500;
	localparam logic [LEN_W-1:0] HDR_SPACE_MIN  = 16'd1125;
	localparam logic [LEN_W-1:0] HDR_SPACE_MAX  = 16'd6750;
	localparam logic [LEN_W-1:0] HDR_REPEAT_MID = 16'd3375;
	localparam logic [LEN_W-1:0] BIT_MARK_MIN   = 16'd281;
	localparam logic [LEN_W-1:0] BIT_MARK_MAX   = 16'd843;
	localparam logic [LEN_W-1:0] BIT_SPACE_MIN  = 16'd281;
	localparam logic [LEN_W-1:0] BIT_SPACE_MAX  = 16'd2530;
	localparam logic [LEN_W-1:0] BIT_SPACE_MID  = 16'd1124;

	localparam logic [POS_W-1:0] POS_HDR_MARK  = 7'd0;
	localparam logic [POS_W-1:0] POS_HDR_SPACE = 7'd1;
	localparam logic [POS_W-1:0] POS_FIRST_BIT = 7'd2;
	localparam logic [POS_W-1:0] POS_LAST      = 7'd65;
	localparam logic [POS_W-1:0] FRAME_EDGES   = 7'd66;

	localparam logic [TICK_W-1:0] TICKS_RESET  = 4'd4;
	localparam logic [TICK_W-1:0] WINDOW_RESET = 4'd4;

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic kind;
		logic level;
		logic hdr_mark_ok;
		logic hdr_space_ok;
		logic hdr_repeat;
		logic bit_mark_ok;
		logic bit_space_ok;
		logic bit_one;
	} class_t;

	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  command;
		logic        repeated;
	} res_t;

endpackage

>>> rtl/nirfd_fifo.sv
// small register queue used between the decoder parts and at the result side
module nirfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/nirfd_front.sv
// front part: range classification of one capture event
module nirfd_front import nirfd_pkg::*; (
	input  logic             kind,
	input  logic             level,
	input  logic [LEN_W-1:0] interval,
	output class_t           cls
);
	always_comb begin
		cls.kind         = kind;
		cls.level        = level;
		cls.hdr_mark_ok  = (interval >= HDR_MARK_MIN) && (interval <= HDR_MARK_MAX);
		cls.hdr_space_ok = (interval >= HDR_SPACE_MIN) && (interval <= HDR_SPACE_MAX);
		cls.hdr_repeat   = (interval < HDR_REPEAT_MID);
		cls.bit_mark_ok  = (interval >= BIT_MARK_MIN) && (interval <= BIT_MARK_MAX);
		cls.bit_space_ok = (interval >= BIT_SPACE_MIN) && (interval <= BIT_SPACE_MAX);
		cls.bit_one      = (interval > BIT_SPACE_MID);
	end

endmodule

>>> rtl/nirfd_back.sv
// back part: frame position tracking, bit assembly and result generation
module nirfd_back import nirfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TICK_W-1:0] window,
	input  class_t            cls,
	input  logic              cls_empty,
	output logic              cls_pop,
	input  logic              res_full,
	output logic              res_push,
	output res_t              res
);
	logic [POS_W-1:0]  pos_q;
	logic [31:0]       bits_q;
	logic              bad_q;
	logic [TICK_W-1:0] ticks_q;
	logic [15:0]       last_address_q;
	logic [7:0]        last_command_q;

	logic              take;
	logic              in_window;
	logic [31:0]       bits_n;
	logic              bad_n;
	logic              check_ok;
	logic [15:0]       frame_address;

	assign take      = !cls_empty && !res_full;
	assign cls_pop   = take;
	assign in_window = (ticks_q < window);

	// bits arrive lsb first, shifted in from the top
	always_comb begin
		bits_n = bits_q;
		bad_n  = bad_q;
		if (pos_q[0] == 1'b0) begin
			if (!cls.bit_mark_ok) begin
				bad_n = 1'b1;
			end
		end else begin
			if (!cls.bit_space_ok) begin
				bad_n = 1'b1;
			end
			bits_n = {cls.bit_one, bits_q[31:1]};
		end
	end

	assign check_ok      = !bad_n && (bits_n[23:16] == ~bits_n[31:24]);
	assign frame_address = {bits_n[7:0], bits_n[15:8]};

	always_comb begin
		res_push = 1'b0;
		res      = '{address: last_address_q, command: last_command_q, repeated: 1'b1};
		if (take && cls.kind == KIND_EDGE) begin
			if (pos_q == POS_HDR_SPACE) begin
				res_push = cls.hdr_space_ok && cls.hdr_repeat && in_window;
			end else if (pos_q == POS_LAST) begin
				res_push = check_ok;
				res      = '{address: frame_address, command: bits_n[23:16], repeated: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= POS_HDR_MARK;
			bits_q         <= '0;
			bad_q          <= 1'b0;
			ticks_q        <= TICKS_RESET;
			last_address_q <= '0;
			last_command_q <= '0;
		end else if (take) begin
			if (cls.kind == KIND_TICK) begin
				pos_q <= POS_HDR_MARK;
				if (in_window) begin
					ticks_q <= ticks_q + 1'b1;
				end
			end else if (pos_q == POS_HDR_MARK || pos_q >= FRAME_EDGES) begin
				pos_q <= POS_HDR_MARK;
				if (cls.level && cls.hdr_mark_ok) begin
					pos_q  <= POS_HDR_SPACE;
					bits_q <= '0;
					bad_q  <= 1'b0;
				end
			end else if (pos_q == POS_HDR_SPACE) begin
				if (!cls.hdr_space_ok) begin
					pos_q <= POS_HDR_MARK;
				end else if (cls.hdr_repeat) begin
					pos_q <= POS_HDR_MARK;
					if (in_window) begin
						ticks_q <= '0;
					end
				end else begin
					ticks_q <= '0;
					pos_q   <= POS_FIRST_BIT;
				end
			end else begin
				bits_q <= bits_n;
				bad_q  <= bad_n;
				if (pos_q == POS_LAST) begin
					pos_q <= POS_HDR_MARK;
					if (check_ok) begin
						last_address_q <= frame_address;
						last_command_q <= bits_n[23:16];
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	a_push_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> take)
		else $error("result pushed without a transaction from the queue");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("frame position out of range");

	a_ticks_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(ticks_q))
		else $error("tick count changed without a transaction");

	a_last_update: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res.repeated |=> last_address_q == $past(res.address))
		else $error("last address not updated after a frame");

endmodule

>>> rtl/nec_ir_frame_decoder_unit.sv
// top level of the nec infrared frame decoder
//
// input channel: an event (kind, level, interval) is a transaction at a rising
// edge with push high and full low. kind 1 is a timeout tick, kind 0 an edge
// with the pin level and the microseconds since the previous edge.
// result channel: while empty is low, address, command and repeated show the
// oldest result; it is taken at a rising edge with pop high.
// the front classifies each event by range compares and queues it; the back
// walks the frame position, assembles the 32 data bits and checks the
// command byte. one event per cycle is sustained while the result queue has
// room; an event is registered in the classified queue, the back reads it
// there, and its result is registered in the result queue for the ports.
// when pop stays low, results collect in the result queue; once it is full
// the back stops taking classified events, and full rises when the classified
// queue fills too. nothing is dropped.
// cfg_we writes cfg_wdata into the repeat window; write only while idle.
// reset empties both queues, sets the window to 4 ticks, closes the repeat
// window and clears the stored address and command.
module nec_ir_frame_decoder_unit import nirfd_pkg::*; #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              kind,
	input  logic              level,
	input  logic [LEN_W-1:0]  interval,
	output logic              empty,
	input  logic              pop,
	output logic [15:0]       address,
	output logic [7:0]        command,
	output logic              repeated,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata
);
	logic [TICK_W-1:0] window_q;
	class_t            cls_in;
	class_t            cls_out;
	logic              cls_empty;
	logic              cls_pop;
	logic              res_full;
	logic              res_push;
	res_t              res_in;
	res_t              res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	nirfd_front u_front (
		.kind     (kind),
		.level    (level),
		.interval (interval),
		.cls      (cls_in)
	);

	nirfd_fifo #(
		.WIDTH ($bits(class_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (cls_pop),
		.rdata  (cls_out),
		.empty  (cls_empty)
	);

	nirfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.window    (window_q),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	nirfd_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign address  = res_out.address;
	assign command  = res_out.command;
	assign repeated = res_out.repeated;

endmodule

>>> sim/nirfd_decode_monitor.sv
// decode monitor: predicts the decoder results from accepted events and checks them in order
module nirfd_decode_monitor import nirfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic              kind,
	input  logic              level,
	input  logic [LEN_W-1:0]  interval,
	input  logic              empty,
	input  logic              pop,
	input  logic [15:0]       address,
	input  logic [7:0]        command,
	input  logic              repeated,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata,
	output int                mismatches,
	output int                codes_pending
);

	logic [TICK_W-1:0] window;
	logic [TICK_W-1:0] ticks;
	logic [POS_W-1:0]  pos;
	logic [31:0]       frame_word;
	logic              frame_spoiled;
	logic [15:0]       held_address;
	logic [7:0]        held_command;
	res_t              codes_due[$];

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// walks one event through the frame position and returns the code it yields
	task automatic decode_event(input logic k, input logic lv, input logic [LEN_W-1:0] len,
			output logic emit, output res_t code);
		logic [POS_W-1:0] space_no;
		emit = 1'b0;
		code = '0;
		if (k == KIND_TICK) begin
			pos = POS_HDR_MARK;
			if (ticks < window) ticks = ticks + 1'b1;
		end else if (pos == POS_HDR_MARK || pos >= FRAME_EDGES) begin
			pos = POS_HDR_MARK;
			if (lv && len >= HDR_MARK_MIN && len <= HDR_MARK_MAX) begin
				frame_word = '0;
				frame_spoiled = 1'b0;
				pos = POS_HDR_SPACE;
			end
		end else if (pos == POS_HDR_SPACE) begin
			if (len < HDR_SPACE_MIN || len > HDR_SPACE_MAX) begin
				pos = POS_HDR_MARK;
			end else if (len < HDR_REPEAT_MID) begin
				pos = POS_HDR_MARK;
				if (ticks < window) begin
					ticks = '0;
					emit = 1'b1;
					code.address = held_address;
					code.command = held_command;
					code.repeated = 1'b1;
				end
			end else begin
				ticks = '0;
				pos = POS_FIRST_BIT;
			end
		end else begin
			if (!pos[0]) begin
				if (len < BIT_MARK_MIN || len > BIT_MARK_MAX) frame_spoiled = 1'b1;
			end else begin
				space_no = (pos - 7'd3) >> 1;
				if (len < BIT_SPACE_MIN || len > BIT_SPACE_MAX) frame_spoiled = 1'b1;
				if (len > BIT_SPACE_MID) frame_word[space_no[4:0]] = 1'b1;
			end
			if (pos == POS_LAST) begin
				pos = POS_HDR_MARK;
				if (!frame_spoiled && frame_word[23:16] == ~frame_word[31:24]) begin
					held_address = {frame_word[7:0], frame_word[15:8]};
					held_command = frame_word[23:16];
					emit = 1'b1;
					code.address = held_address;
					code.command = held_command;
					code.repeated = 1'b0;
				end
			end else begin
				pos = pos + 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic emit;
		res_t code;
		res_t want;
		if (!arst_n) begin
			window = WINDOW_RESET;
			ticks = TICKS_RESET;
			pos = POS_HDR_MARK;
			frame_word = '0;
			frame_spoiled = 1'b0;
			held_address = '0;
			held_command = '0;
			codes_due.delete();
			codes_pending = 0;
			mismatches = 0;
		end else begin
			if (pop && !empty) begin
				if (codes_due.size() == 0) begin
					flag_mismatch("unexpected result", 32'({address, command, repeated}), '0);
				end else begin
					want = codes_due.pop_front();
					if (address !== want.address) begin
						flag_mismatch("address", 32'(address), 32'(want.address));
					end
					if (command !== want.command) begin
						flag_mismatch("command", 32'(command), 32'(want.command));
					end
					if (repeated !== want.repeated) begin
						flag_mismatch("repeated", 32'(repeated), 32'(want.repeated));
					end
				end
			end
			if (cfg_we) window = cfg_wdata;
			if (push && !full) begin
				decode_event(kind, level, interval, emit, code);
				if (emit) codes_due.push_back(code);
			end
			codes_pending = codes_due.size();
		end
	end

endmodule

>>> sim/tb.sv
// testbench top: drives edge events and ticks into the nec ir decoder and gives the verdict
module tb import nirfd_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 170;

	typedef enum int {FLAW_NONE, FLAW_MARK, FLAW_SPACE, FLAW_CHECK, FLAW_CUT} flaw_t;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic              kind;
	logic              level;
	logic [LEN_W-1:0]  interval;
	logic              empty;
	logic              pop;
	logic [15:0]       address;
	logic [7:0]        command;
	logic              repeated;
	logic              cfg_we;
	logic [TICK_W-1:0] cfg_wdata;
	int                mismatches;
	int                codes_pending;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_left;
	int items_sent;
	int cycles = 0;

	nec_ir_frame_decoder_unit dut (.*);

	nirfd_decode_monitor monitor (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : result_taker
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic logic coin();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [LEN_W-1:0] any_len();
		return LEN_W'($urandom_range(65535));
	endfunction

	function automatic logic [LEN_W-1:0] in_span(input logic [LEN_W-1:0] lo,
			input logic [LEN_W-1:0] hi);
		int unsigned roll;
		roll = $urandom_range(5);
		if (roll == 0) return lo;
		if (roll == 1) return hi;
		return LEN_W'($urandom_range(32'(hi), 32'(lo)));
	endfunction

	function automatic logic [LEN_W-1:0] off_span(input logic [LEN_W-1:0] lo,
			input logic [LEN_W-1:0] hi);
		if ($urandom_range(1) == 0) begin
			return ($urandom_range(1) == 0) ? lo - 16'd1
				: LEN_W'($urandom_range(32'(lo) - 1, 0));
		end
		return ($urandom_range(1) == 0) ? hi + 16'd1
			: LEN_W'($urandom_range(65535, 32'(hi) + 1));
	endfunction

	function automatic logic [15:0] corner_or_random(input int w);
		int unsigned roll;
		roll = $urandom_range(4);
		if (roll == 0) return '0;
		if (roll == 1) return 16'((1 << w) - 1);
		return 16'($urandom_range((1 << w) - 1));
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic offer(input logic k, input logic lv, input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		kind <= k;
		level <= lv;
		interval <= len;
		do @(posedge clk); while (full);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (codes_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_window(input logic [TICK_W-1:0] ticks);
		cfg_we <= 1'b1;
		cfg_wdata <= ticks;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_repeat();
		offer(KIND_EDGE, 1'b1, in_span(HDR_MARK_MIN, HDR_MARK_MAX));
		offer(KIND_EDGE, coin(), in_span(HDR_SPACE_MIN, HDR_REPEAT_MID - 16'd1));
	endtask

	task automatic send_frame(input logic [15:0] addr, input logic [7:0] cmd, input flaw_t flaw);
		logic [31:0]      word;
		logic [LEN_W-1:0] len;
		int               flip;
		int               bad_at;
		int               cut_at;
		word = {~cmd, cmd, addr[7:0], addr[15:8]};
		flip = $urandom_range(7);
		if (flaw == FLAW_CHECK) word[24 + flip] = ~word[24 + flip];
		bad_at = -1;
		if (flaw == FLAW_MARK) bad_at = 2 * $urandom_range(31);
		if (flaw == FLAW_SPACE) bad_at = 2 * $urandom_range(31) + 1;
		cut_at = $urandom_range(63);
		offer(KIND_EDGE, 1'b1, in_span(HDR_MARK_MIN, HDR_MARK_MAX));
		offer(KIND_EDGE, coin(), in_span(HDR_REPEAT_MID, HDR_SPACE_MAX));
		for (int i = 0; i < 64; i++) begin
			if (flaw == FLAW_CUT && i == cut_at) begin
				offer(KIND_TICK, coin(), any_len());
				return;
			end
			if (i % 2 == 0) begin
				len = (i == bad_at) ? off_span(BIT_MARK_MIN, BIT_MARK_MAX)
					: in_span(BIT_MARK_MIN, BIT_MARK_MAX);
			end else if (i == bad_at) begin
				len = off_span(BIT_SPACE_MIN, BIT_SPACE_MAX);
			end else if (word[i / 2]) begin
				len = in_span(BIT_SPACE_MID + 16'd1, BIT_SPACE_MAX);
			end else begin
				len = in_span(BIT_SPACE_MIN, BIT_SPACE_MID);
			end
			offer(KIND_EDGE, coin(), len);
		end
	endtask

	initial begin : stimulus
		int    target;
		int    roll;
		flaw_t flaw;
		logic [TICK_W-1:0] window_plan [6];
		arst_n = 1'b0;
		push = 1'b0;
		kind = KIND_EDGE;
		level = 1'b0;
		interval = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_left = 0;
		items_sent = 0;
		window_plan = '{4'd15, 4'd0, 4'd1, 4'd9, 4'd2, 4'd4};
		window_plan[3] = TICK_W'($urandom_range(15));
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// header corner cases under the reset window
		offer(KIND_TICK, 1'b0, '0);
		offer(KIND_TICK, 1'b1, '1);
		offer(KIND_EDGE, 1'b0, HDR_MARK_MIN);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MIN - 16'd1);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MAX + 16'd1);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MIN);
		offer(KIND_EDGE, 1'b0, HDR_SPACE_MIN - 16'd1);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MAX);
		offer(KIND_EDGE, 1'b1, HDR_SPACE_MAX + 16'd1);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MAX);
		offer(KIND_EDGE, 1'b0, HDR_REPEAT_MID - 16'd1);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MIN);
		offer(KIND_EDGE, 1'b0, HDR_REPEAT_MID);
		offer(KIND_TICK, 1'b0, '0);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MIN);
		offer(KIND_EDGE, 1'b1, HDR_SPACE_MIN);
		repeat (4) offer(KIND_TICK, 1'b1, '0);
		offer(KIND_EDGE, 1'b1, HDR_MARK_MAX);
		offer(KIND_EDGE, 1'b0, HDR_SPACE_MIN);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			set_window(window_plan[ph]);
			tx_idle_pct = (ph % 4 == 1) ? 48 : (ph % 4 == 3) ? 10 : 0;
			rx_stall_pct = (ph % 4 == 2) ? 48 : (ph % 4 == 3) ? 10 : 0;
			if (ph == 0) begin
				// receiver holds off while repeats pile up behind a frame
				hold_left = 400;
				send_frame(corner_or_random(16), 8'(corner_or_random(8)), FLAW_NONE);
				repeat (24) send_repeat();
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					flaw = ($urandom_range(9) < 6) ? FLAW_NONE : flaw_t'($urandom_range(4, 1));
					send_frame(corner_or_random(16), 8'(corner_or_random(8)), flaw);
				end else if (roll < 70) begin
					if ($urandom_range(3) == 0) begin
						repeat ($urandom_range(3, 1)) offer(KIND_TICK, coin(), '0);
					end
					send_repeat();
				end else if (roll < 80) begin
					repeat ($urandom_range(3, 1)) begin
						offer(KIND_TICK, coin(), any_len());
					end
				end else if (roll < 88) begin
					if ($urandom_range(1) == 0) begin
						offer(KIND_EDGE, coin(), off_span(HDR_MARK_MIN, HDR_MARK_MAX));
						offer(KIND_EDGE, 1'b0, in_span(HDR_MARK_MIN, HDR_MARK_MAX));
					end else begin
						offer(KIND_EDGE, 1'b1, in_span(HDR_MARK_MIN, HDR_MARK_MAX));
						offer(KIND_EDGE, coin(), off_span(HDR_SPACE_MIN, HDR_SPACE_MAX));
					end
				end else begin
					repeat ($urandom_range(4, 1)) begin
						offer(coin(), coin(), any_len());
					end
				end
			end
			// leave the tick count high so a lower window can start below it
			repeat ($urandom_range(16)) offer(KIND_TICK, coin(), '0);
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
